[sv/twdp_pkg.sv]
`timescale 1ns / 1ps

package twdp_pkg;

    // Field widths of the stream and the register.
    localparam int ACT_W   = 62;
    localparam int CODE_W  = 2;
    localparam int LIMIT_W = 61;
    localparam int RES_W   = 62;
    localparam int ACC_W   = 128;
    localparam int HALF_W  = 64;

    // Packed beat widths, padded to whole bytes.
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 64;

    // Ternary weight codes.
    localparam logic [CODE_W-1:0] CODE_ZERO = 2'd0;
    localparam logic [CODE_W-1:0] CODE_ADD  = 2'd1;
    localparam logic [CODE_W-1:0] CODE_SUB  = 2'd2;
    localparam logic [CODE_W-1:0] CODE_NONE = 2'd3;

    // Largest value that 39 balanced trits can hold.
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 61'd2026277576509488133;

    // A finished dot product on its way from the accumulator to the clamp.
    typedef struct packed {
        logic             valid;
        logic [ACC_W-1:0] sum;
    } sum_beat_t;

endpackage

[sv/twdp_accum.sv]
`timescale 1ns / 1ps

module twdp_accum
    import twdp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [ACT_W-1:0]  in_act,
    input  logic [CODE_W-1:0] in_code,
    input  logic              in_last,
    output sum_beat_t         sum_beat,
    input  logic              sum_ready
);

    // Input register.
    logic              a_valid_reg;
    logic              a_valid_next;
    logic [ACT_W-1:0]  a_act_reg;
    logic [CODE_W-1:0] a_code_reg;
    logic              a_last_reg;

    // Accumulator and the finished-sum register.
    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  acc_next;
    logic              b_valid_reg;
    logic              b_valid_next;
    logic [ACC_W-1:0]  b_sum_reg;

    logic              b_free;
    logic              a_fire;
    logic              in_fire;
    logic [ACC_W-1:0]  term_ext;
    logic [ACC_W-1:0]  operand;
    logic              carry_in;
    logic [ACC_W-1:0]  sum_now;

    assign b_free   = !b_valid_reg || sum_ready;
    // A term that is not last only needs the accumulator, never the sum register.
    assign a_fire   = a_valid_reg && (!a_last_reg || b_free);
    assign in_ready = !a_valid_reg || a_fire;
    assign in_fire  = in_valid && in_ready;

    assign term_ext = {{(ACC_W-ACT_W){a_act_reg[ACT_W-1]}}, a_act_reg};

    // Subtraction is done as adding the complement with a carry in.
    always_comb
    begin
        unique case (a_code_reg)
            CODE_ADD:
            begin
                operand  = term_ext;
                carry_in = 1'b0;
            end
            CODE_SUB:
            begin
                operand  = ~term_ext;
                carry_in = 1'b1;
            end
            default:
            begin
                operand  = '0;
                carry_in = 1'b0;
            end
        endcase
    end

    assign sum_now = acc_reg + operand + {{(ACC_W-1){1'b0}}, carry_in};

    always_comb
    begin
        acc_next     = acc_reg;
        a_valid_next = a_valid_reg;
        b_valid_next = b_valid_reg;
        if (b_valid_reg && sum_ready)
        begin
            b_valid_next = 1'b0;
        end
        if (a_fire)
        begin
            acc_next     = a_last_reg ? '0 : sum_now;
            a_valid_next = 1'b0;
            if (a_last_reg)
            begin
                b_valid_next = 1'b1;
            end
        end
        if (in_fire)
        begin
            a_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            acc_reg     <= '0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            acc_reg     <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_act_reg  <= in_act;
            a_code_reg <= in_code;
            a_last_reg <= in_last;
        end
        if (a_fire && a_last_reg)
        begin
            b_sum_reg <= sum_now;
        end
    end

    assign sum_beat.valid = b_valid_reg;
    assign sum_beat.sum   = b_sum_reg;

    // A closed dot product leaves the accumulator empty for the next one.
    assert property (@(posedge clk) disable iff (!rst_n)
        a_fire && a_last_reg |=> acc_reg == '0)
        else $error("accumulator not cleared after last term");

    // A finished sum that the clamp has not taken stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && !sum_ready |=> b_valid_reg && $stable(b_sum_reg))
        else $error("finished sum lost while stalled");

endmodule

[sv/twdp_clamp.sv]
`timescale 1ns / 1ps

module twdp_clamp
    import twdp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [LIMIT_W-1:0] limit,
    input  sum_beat_t          sum_beat,
    output logic               sum_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [RES_W-1:0]   out_data
);

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [RES_W-1:0]   out_data_reg;
    logic [HALF_W-1:0]  hi;
    logic [HALF_W-1:0]  lo;
    logic [HALF_W-1:0]  pos_lim;
    logic [HALF_W-1:0]  neg_lim;
    logic               pos_ok;
    logic               neg_ok;
    logic [HALF_W-1:0]  clamped;
    logic               take;

    assign hi      = sum_beat.sum[ACC_W-1:HALF_W];
    assign lo      = sum_beat.sum[HALF_W-1:0];
    assign pos_lim = {{(HALF_W-LIMIT_W){1'b0}}, limit};
    assign neg_lim = '0 - pos_lim;

    // The sum is in range only if it already fits the low word and lies inside the bound.
    assign pos_ok = (hi == '0) && !lo[HALF_W-1] && (lo <= pos_lim);
    assign neg_ok = (&hi) && lo[HALF_W-1] && ($signed(lo) >= $signed(neg_lim));

    always_comb
    begin
        if (hi[HALF_W-1])
        begin
            clamped = neg_ok ? lo : neg_lim;
        end
        else
        begin
            clamped = pos_ok ? lo : pos_lim;
        end
    end

    assign sum_ready = !out_valid_reg || out_ready;
    assign take      = sum_beat.valid && sum_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (take)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_data_reg <= clamped[RES_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Every emitted result lies within the bound.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ($signed(out_data_reg) <= $signed({1'b0, limit}))
                       && ($signed(out_data_reg) >= -$signed({1'b0, limit})))
        else $error("result outside saturation bound");

    // A result waiting on the consumer is not replaced.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(out_data_reg))
        else $error("pending result overwritten");

endmodule

[sv/ternary_weight_dot_product.sv]
`timescale 1ns / 1ps
// A last-marked term passes the input, sum and output registers to reach m_axis.
// One term per cycle unless stalled; the 128-bit accumulator add is the loop.
// Only non-last terms flow on while results wait in the sum and output registers.
// Reset (rst_n low, asynchronous) empties the pipeline, zeroes the accumulator
// and sets the saturation limit to the 39-trit maximum.

module ternary_weight_dot_product
    import twdp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    // Input terms. tdata: [61:0] activation, [63:62] weight_code.
    // tlast marks the last term of a dot product.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tlast,

    // Results. tdata: [61:0] dot_result, [63:62] zero.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,

    // Saturation limit register write.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [LIMIT_W-1:0]    cfg_data
);

    logic [LIMIT_W-1:0] limit_reg;
    sum_beat_t          sum_beat;
    logic               sum_ready;
    logic [RES_W-1:0]   dot_result;

    // The limit register is always writable; the user must change it only while no
    // dot product is in flight, so the clamp sees one value per result; unenforced.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            limit_reg <= cfg_data;
        end
    end

    // Input register, the running sum and the finished-sum register.
    twdp_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_act    (s_axis_tdata[ACT_W-1:0]),
        .in_code   (s_axis_tdata[ACT_W+CODE_W-1:ACT_W]),
        .in_last   (s_axis_tlast),
        .sum_beat  (sum_beat),
        .sum_ready (sum_ready)
    );

    // Saturation to plus or minus the limit and the output register.
    twdp_clamp u_clamp (
        .clk       (clk),
        .rst_n     (rst_n),
        .limit     (limit_reg),
        .sum_beat  (sum_beat),
        .sum_ready (sum_ready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (dot_result)
    );

    assign m_axis_tdata = {{(OUT_DATA_W-RES_W){1'b0}}, dot_result};

endmodule

[tb/ternary_weight_dot_product_tb.sv]
`timescale 1ns / 1ps

module ternary_weight_dot_product_tb;
    import twdp_pkg::*;

    // Run-level constants.
    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;

    // Activation patterns at the edges of the field and of the 39-trit range.
    localparam logic [ACT_W-1:0] ACT_TOP    = ACT_W'(LIMIT_RESET);
    localparam logic [ACT_W-1:0] ACT_BOTTOM = ~ACT_TOP + 1'b1;
    localparam logic [ACT_W-1:0] ACT_MAXPAT = {1'b0, {(ACT_W-1){1'b1}}};
    localparam logic [ACT_W-1:0] ACT_MINPAT = {1'b1, {(ACT_W-1){1'b0}}};
    localparam logic [LIMIT_W-1:0] LIMIT_TOP = {LIMIT_W{1'b1}};

    // One term of a dot product as the feeder sees it.
    typedef struct {
        logic [ACT_W-1:0]  act;
        logic [CODE_W-1:0] code;
        logic              is_last;
    } term_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tlast  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [LIMIT_W-1:0]    cfg_data      = '0;

    // Terms waiting to be offered, and the term currently on the input bus.
    term_t term_queue[$];
    term_t term_on_bus;

    // Shadow of the block: its accumulator and its saturation limit.
    logic signed [ACC_W-1:0] shadow_sum   = '0;
    logic [LIMIT_W-1:0]      shadow_limit = LIMIT_RESET;

    // Clamped sums that the block still owes us, oldest first.
    logic [RES_W-1:0] owed_sums[$];

    // Idle percentages per side, set per phase by the stimulus process.
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int src_gap       = 0;
    int sink_gap      = 0;

    // A bump of hold_req asks the sink to stop taking results for a while.
    int hold_req  = 0;
    int hold_seen = 0;
    int hold_left = 0;

    int error_count = 0;
    int cycle_count = 0;

    ternary_weight_dot_product DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [61:0] activation, [63:62] weight_code
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [61:0] dot_result, [63:62] zero
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // Gaps are zero unless the idle percentage hits; then about one in ten is long, the rest short.
    function automatic int pick_gap(int pct);
        if ($urandom_range(99) >= pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(30, 8);
        return $urandom_range(3, 1);
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        error_count++;
    endtask

    // Fold one accepted term into the shadow accumulator. A last-marked term
    // clamps the 128-bit sum to the limit, owes that value as a result, and
    // clears the sum. Codes zero and three contribute nothing.
    function automatic void fold_term(term_t t);
        logic signed [ACT_W-1:0] act_s;
        logic signed [ACC_W-1:0] widened;
        logic signed [ACC_W-1:0] bound;
        logic signed [ACC_W-1:0] clamped;
        act_s   = t.act;
        widened = ACC_W'(act_s);
        bound   = {{(ACC_W-LIMIT_W){1'b0}}, shadow_limit};
        case (t.code)
            CODE_ADD: shadow_sum = shadow_sum + widened;
            CODE_SUB: shadow_sum = shadow_sum - widened;
            default: ;
        endcase
        if (t.is_last)
        begin
            if (shadow_sum > bound)
                clamped = bound;
            else if (shadow_sum < -bound)
                clamped = -bound;
            else
                clamped = shadow_sum;
            owed_sums.push_back(clamped[RES_W-1:0]);
            shadow_sum = '0;
        end
    endfunction

    // Input driver: offers terms from the queue, with random gaps between beats.
    // The shadow model sees each term at the edge where its beat is taken.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                fold_term(term_on_bus);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (term_queue.size() > 0)
                begin
                    term_on_bus = term_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {term_on_bus.code, term_on_bus.act};
                    s_axis_tlast  <= term_on_bus.is_last;
                    src_gap = pick_gap(src_idle_pct);
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result sink: owns m_axis_tready. A hold request freezes it for a long
    // stretch so that results back up into the block and it stalls its input.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (sink_gap > 0)
            begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                sink_gap = pick_gap(sink_idle_pct);
                m_axis_tready <= (sink_gap == 0);
                if (sink_gap > 0)
                    sink_gap--;
            end
        end
    end

    // Result checker: every beat taken must match the oldest owed sum.
    always @(posedge clk)
    begin
        logic [RES_W-1:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (owed_sums.size() == 0)
            begin
                report_mismatch("unexpected result", m_axis_tdata, '0);
            end
            else
            begin
                want = owed_sums.pop_front();
                if (m_axis_tdata[RES_W-1:0] !== want)
                    report_mismatch("dot_result", 64'(m_axis_tdata[RES_W-1:0]), 64'(want));
                if (m_axis_tdata[OUT_DATA_W-1:RES_W] !== '0)
                    report_mismatch("padding", 64'(m_axis_tdata[OUT_DATA_W-1:RES_W]), '0);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL ternary_weight_dot_product");
            $finish;
        end
    end

    task automatic push_term(logic [ACT_W-1:0] act, logic [CODE_W-1:0] code, logic is_last);
        term_t t;
        t.act     = act;
        t.code    = code;
        t.is_last = is_last;
        term_queue.push_back(t);
    endtask

    // Waits until every term is on its way and every owed sum has come back,
    // then waits out SETTLE_CYCLES for terms that owe no result.
    task automatic wait_idle();
        while (term_queue.size() != 0 || s_axis_tvalid || owed_sums.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the saturation limit; only called while the block is idle.
    task automatic write_limit(logic [LIMIT_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        shadow_limit = value;
    endtask

    // A random activation: full patterns, small values, field extremes, or
    // values close to the current limit so that the clamp edge gets hit.
    function automatic logic [ACT_W-1:0] rand_activation();
        logic signed [ACT_W-1:0] small_v;
        logic [ACT_W-1:0]        lim62;
        int                      pick;
        pick    = $urandom_range(9);
        small_v = ACT_W'($signed($urandom_range(2000)) - 1000);
        lim62   = ACT_W'(shadow_limit);
        case (pick)
            0, 1, 2, 3: return ACT_W'({$urandom, $urandom});
            4, 5, 6:    return small_v;
            7:
            begin
                case ($urandom_range(5))
                    0: return ACT_MAXPAT;
                    1: return ACT_MINPAT;
                    2: return ACT_TOP;
                    3: return ACT_BOTTOM;
                    4: return '0;
                    default: return '1;
                endcase
            end
            8: return lim62 + ACT_W'(small_v);
            default: return ACT_W'(small_v) - lim62;
        endcase
    endfunction

    // Queues dot products of random length until about n_terms are queued.
    // Most runs are short; now and then a long one comes along.
    task automatic queue_random_runs(int n_terms);
        int queued;
        int run_len;
        queued = 0;
        while (queued < n_terms)
        begin
            run_len = ($urandom_range(9) == 0) ? $urandom_range(40, 8) : $urandom_range(6, 1);
            for (int k = 0; k < run_len; k++)
                push_term(rand_activation(), CODE_W'($urandom_range(3)), k == run_len - 1);
            queued += run_len;
        end
    endtask

    initial
    begin
        logic [LIMIT_W-1:0] lim;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed terms under the reset limit.
        src_idle_pct  = 20;
        sink_idle_pct = 20;
        push_term(ACT_TOP,    CODE_ADD,  1'b1);
        push_term(ACT_BOTTOM, CODE_ADD,  1'b1);
        push_term(ACT_TOP,    CODE_SUB,  1'b1);
        push_term(ACT_BOTTOM, CODE_SUB,  1'b1);
        push_term(ACT_TOP,    CODE_ZERO, 1'b1);
        push_term(ACT_TOP,    CODE_NONE, 1'b1);
        // Activations beyond the nominal range are taken as they are.
        push_term(ACT_MAXPAT, CODE_ADD,  1'b1);
        push_term(ACT_MINPAT, CODE_ADD,  1'b1);
        push_term(ACT_MINPAT, CODE_SUB,  1'b1);
        // A plus and a minus of the same value cancel; a code-three term lies between.
        push_term(ACT_TOP,    CODE_ADD,  1'b0);
        push_term(ACT_MAXPAT, CODE_NONE, 1'b0);
        push_term(ACT_TOP,    CODE_SUB,  1'b1);
        // Sums past the signed 64-bit range in both directions must still clamp.
        for (int k = 0; k < 6; k++)
            push_term(ACT_MINPAT, CODE_SUB, k == 5);
        for (int k = 0; k < 6; k++)
            push_term(ACT_MINPAT, CODE_ADD, k == 5);
        wait_idle();

        // A zero limit pins every result to zero.
        write_limit('0);
        push_term(ACT_MAXPAT, CODE_ADD, 1'b1);
        push_term(ACT_MINPAT, CODE_ADD, 1'b1);
        queue_random_runs(60);
        wait_idle();

        // The largest 61-bit limit, above the nominal range.
        write_limit(LIMIT_TOP);
        push_term(ACT_MAXPAT, CODE_ADD, 1'b1);
        push_term(ACT_MINPAT, CODE_ADD, 1'b1);
        push_term(ACT_MAXPAT, CODE_SUB, 1'b1);
        queue_random_runs(100);
        wait_idle();

        // A limit of one, with no idling on either side.
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        write_limit(LIMIT_W'(1));
        queue_random_runs(60);
        wait_idle();

        // Back pressure: the sink holds off while single-term dot products
        // keep coming, so the block fills up and stops taking terms.
        write_limit(LIMIT_RESET);
        hold_req++;
        for (int k = 0; k < 60; k++)
            push_term(rand_activation(), CODE_W'($urandom_range(3)), 1'b1);
        wait_idle();

        // Random phases with varied limits and idling.
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: lim = LIMIT_W'({$urandom, $urandom});
                1: lim = LIMIT_W'($urandom_range(5000));
                2: lim = LIMIT_W'({$urandom_range(255), $urandom});
                3: lim = LIMIT_RESET;
                default: lim = LIMIT_W'({$urandom, $urandom}) >> $urandom_range(40);
            endcase
            src_idle_pct  = $urandom_range(60);
            sink_idle_pct = $urandom_range(60);
            write_limit(lim);
            queue_random_runs(100);
            wait_idle();
        end

        if (error_count == 0)
            $display("PASS ternary_weight_dot_product");
        else
            $display("FAIL ternary_weight_dot_product");
        $finish;
    end

endmodule

[files.f]
sv/twdp_pkg.sv
sv/twdp_accum.sv
sv/twdp_clamp.sv
sv/ternary_weight_dot_product.sv
tb/ternary_weight_dot_product_tb.sv
